@@ design/gcl_pkg.sv @@
// Shared types and constants for the GCD / LCM unit.
`default_nettype none

package gcl_pkg;

    localparam int DATA_W  = 64;
    localparam int CNT_W   = 6;
    localparam int SHIFT_W = 6;

    localparam logic [DATA_W-1:0] LCM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_GCD_STEP,
        CMD_GCD_END,
        CMD_DIV_STEP,
        CMD_MUL_STEP,
        CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic lcm_path;
        logic cnt_last;
    } status_t;

endpackage

`default_nettype wire

@@ design/gcl_datapath.sv @@
// Datapath of the GCD / LCM unit: binary GCD, restoring divider, shift-add multiplier.
`default_nettype none

module gcl_datapath
    import gcl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              kind,
    input  wire logic [DATA_W-1:0] operand_a,
    input  wire logic [DATA_W-1:0] operand_b,
    output logic [DATA_W-1:0]      result,
    output logic                   overflow
);

    logic              kind_reg, kind_next;
    logic              zero_reg, zero_next;
    logic [DATA_W-1:0] ma_reg, ma_next;
    logic [DATA_W-1:0] mb_reg, mb_next;
    logic [DATA_W-1:0] u_reg, u_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic [DATA_W-1:0] g_reg, g_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic [DATA_W-1:0] result_reg, result_next;
    logic              overflow_reg, overflow_next;

    logic [DATA_W-1:0] mag_a, mag_b;
    logic [DATA_W-1:0] u_minus_v, v_minus_u;
    logic              u_ge_v;
    logic [DATA_W:0]   rem_sh;
    logic              rem_ge;
    logic [DATA_W:0]   rem_diff;
    logic [DATA_W:0]   mul_sum;
    logic [DATA_W-1:0] final_value;
    logic              final_ovf;

    assign mag_a = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;

    assign u_minus_v = u_reg - v_reg;
    assign v_minus_u = v_reg - u_reg;
    assign u_ge_v    = (u_reg >= v_reg);

    assign rem_sh   = {rem_reg, q_reg[DATA_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, g_reg});
    assign rem_diff = rem_sh - {1'b0, g_reg};

    assign mul_sum = {acc_reg, 1'b0} + (q_reg[DATA_W-1] ? {1'b0, mb_reg} : '0);

    always_comb
    begin
        if (kind_reg && zero_reg)
        begin
            final_value = '0;
            final_ovf   = 1'b0;
        end
        else if (kind_reg)
        begin
            final_value = ovf_reg ? LCM_LIMIT : acc_reg;
            final_ovf   = ovf_reg;
        end
        else
        begin
            final_value = g_reg;
            final_ovf   = 1'b0;
        end
    end

    always_comb
    begin
        kind_next     = kind_reg;
        zero_next     = zero_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        k_next        = k_reg;
        g_next        = g_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        result_next   = result_reg;
        overflow_next = overflow_reg;
        case (cmd)
            CMD_LOAD:
            begin
                kind_next = kind;
                zero_next = (mag_a == '0) || (mag_b == '0);
                ma_next   = mag_a;
                mb_next   = mag_b;
                u_next    = mag_a;
                v_next    = mag_b;
                k_next    = '0;
                cnt_next  = '0;
                acc_next  = '0;
                ovf_next  = 1'b0;
            end
            CMD_GCD_STEP:
            begin
                // Common factors of two are counted in k and restored at the end.
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_ge_v)
                begin
                    u_next = u_minus_v >> 1;
                end
                else
                begin
                    v_next = v_minus_u >> 1;
                end
            end
            CMD_GCD_END:
            begin
                // One of u and v is zero here, so the OR picks the other.
                g_next   = (u_reg | v_reg) << k_reg;
                q_next   = ma_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            CMD_DIV_STEP:
            begin
                rem_next = rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            CMD_MUL_STEP:
            begin
                // Quotient bits enter MSB first; the partial product only grows,
                // so once it passes the limit the flag is final.
                q_next   = {q_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (!ovf_reg)
                begin
                    if (mul_sum > {1'b0, LCM_LIMIT})
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mul_sum[DATA_W-1:0];
                    end
                end
            end
            CMD_PUBLISH:
            begin
                result_next   = final_value;
                overflow_next = final_ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            zero_reg <= 1'b0;
            k_reg    <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            kind_reg <= kind_next;
            zero_reg <= zero_next;
            k_reg    <= k_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        acc_reg      <= acc_next;
        result_reg   <= result_next;
        overflow_reg <= overflow_next;
    end

    assign status.gcd_done = (u_reg == '0) || (v_reg == '0);
    assign status.lcm_path = kind_reg && !zero_reg;
    assign status.cnt_last = &cnt_reg;

    assign result   = result_reg;
    assign overflow = overflow_reg;

endmodule

`default_nettype wire

@@ design/gcl_controller.sv @@
// Sequencer of the GCD / LCM unit: handshakes and datapath commands.
`default_nettype none

module gcl_controller
    import gcl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd        = CMD_GCD_END;
                    state_next = status.lcm_path ? S_DIV : S_DONE;
                end
                else
                begin
                    cmd = CMD_GCD_STEP;
                end
            end
            S_DIV:
            begin
                cmd = CMD_DIV_STEP;
                if (status.cnt_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd = CMD_MUL_STEP;
                if (status.cnt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd            = CMD_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_publish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUBLISH) |-> (!out_valid_reg || !out_stall))
        else $error("result published over an unread result");

    a_accept_starts_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_GCD))
        else $error("accepted item did not start the GCD loop");

    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.cnt_last) |=> (state_reg == S_MUL))
        else $error("divider did not hand over to the multiplier");

    a_done_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not published to a free output");

endmodule

`default_nettype wire

@@ design/gcd_lcm_unit.sv @@
// Top level of the GCD / LCM unit: controller and datapath.
// Each item takes the magnitudes of two signed 64-bit operands and returns their
// GCD (kind 0) or LCM (kind 1); an LCM above 2^63-1 saturates and sets overflow.
// One item is in work at a time. The GCD runs a binary (shift and subtract)
// loop at one step per cycle. Every step drops at least one bit from u or v,
// so full-width operands need at most 128 steps, and small ones need fewer.
// An LCM with two nonzero operands then runs a bit-serial restoring divider
// and a shift-add multiplier. Load, hand-off and publish are steps of their
// own, and a finished result may wait for the output register to be free.
// The output register holds a finished result while the next item is accepted.
`default_nettype none

module gcd_lcm_unit
    import gcl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              kind,
    input  wire logic [DATA_W-1:0] operand_a,
    input  wire logic [DATA_W-1:0] operand_b,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      result,
    output logic                   overflow
);

    cmd_t    cmd;
    status_t status;

    gcl_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gcl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .result    (result),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

@@ tb/gcd_lcm_unit_tb.sv @@
// Self-checking testbench for gcd_lcm_unit: directed corners, then random operand pairs.
`timescale 1ns / 100ps

module gcd_lcm_unit_tb
    import gcl_pkg::*;
();

    localparam logic KIND_GCD = 1'b0;
    localparam logic KIND_LCM = 1'b1;

    localparam logic [DATA_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = LCM_LIMIT;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } answer_t;

    // Holds the answers still owed by the block and checks each one as it leaves.
    class gcl_checker;
        answer_t answers_due[$];
        int      failures;
        int      checked;
        int      gcd_items;
        int      lcm_items;
        int      saturated;

        function new();
            failures  = 0;
            checked   = 0;
            gcd_items = 0;
            lcm_items = 0;
            saturated = 0;
        endfunction

        function logic [DATA_W-1:0] magnitude_of(logic [DATA_W-1:0] v);
            return v[DATA_W-1] ? (~v) + 1'b1 : v;
        endfunction

        function logic [DATA_W-1:0] euclid_gcd(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
            logic [DATA_W-1:0] r;
            while (y != '0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function answer_t predict_answer(logic k, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            answer_t           ans;
            logic [DATA_W-1:0] ma;
            logic [DATA_W-1:0] mb;
            logic [DATA_W-1:0] q;
            ma = magnitude_of(a);
            mb = magnitude_of(b);
            ans.ovf = 1'b0;
            if (k == KIND_GCD)
                ans.value = euclid_gcd(ma, mb);
            else if (ma == '0 || mb == '0)
                ans.value = '0;
            else
            begin
                q = ma / euclid_gcd(ma, mb);
                // Compare against the limit by division so the product never wraps.
                if (q > LCM_LIMIT / mb)
                begin
                    ans.value = LCM_LIMIT;
                    ans.ovf   = 1'b1;
                end
                else
                    ans.value = q * mb;
            end
            return ans;
        endfunction

        function void note_operands(logic k, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            answer_t ans;
            ans = predict_answer(k, a, b);
            if (k == KIND_GCD)
                gcd_items++;
            else
                lcm_items++;
            if (ans.ovf)
                saturated++;
            answers_due.push_back(ans);
        endfunction

        function void check_answer(logic [DATA_W-1:0] value, logic ovf);
            answer_t want;
            checked++;
            if (answers_due.size() == 0)
            begin
                $error("result arrived with no item outstanding: result %h overflow %b",
                       value, ovf);
                failures++;
                return;
            end
            want = answers_due.pop_front();
            if (value !== want.value)
            begin
                $error("result mismatch: expected %h, actual %h", want.value, value);
                failures++;
            end
            if (ovf !== want.ovf)
            begin
                $error("overflow mismatch: expected %b, actual %b", want.ovf, ovf);
                failures++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              kind = KIND_GCD;
    logic [DATA_W-1:0] operand_a = '0;
    logic [DATA_W-1:0] operand_b = '0;
    logic              out_stall = 1'b0;
    wire               in_stall;
    wire               out_valid;
    wire  [DATA_W-1:0] result;
    wire               overflow;

    gcl_checker checker_h = new();
    int         sent_count = 0;
    int         cycle_count = 0;
    bit         hold_done = 1'b0;

    gcd_lcm_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .overflow  (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Inputs only change at the rising edge, so the falling edge sees what the next edge takes.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n)
            begin
                if (in_valid && !in_stall)
                    checker_h.note_operands(kind, operand_a, operand_b);
                if (out_valid && !out_stall)
                    checker_h.check_answer(result, overflow);
            end
        end
    end

    // Result side: occasional random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        bit calm;
        forever
        begin
            @(posedge clk);
            if (!hold_done && checker_h.checked >= 900)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            calm = checker_h.checked >= 400 && checker_h.checked < 700;
            out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    task automatic send_item(input logic k, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        int gap;
        gap = 0;
        if (!(sent_count >= 400 && sent_count < 700) && $urandom_range(0, 99) < 10)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        operand_a <= a;
        operand_b <= b;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        int                sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            v = {$urandom, $urandom};
        else if (sel < 75)
            v = 64'($urandom_range(0, 2000));
        else if (sel < 90)
            v = 64'($urandom) << $urandom_range(0, 31);
        else
        begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = 64'd1;
                2: v = MOST_NEG;
                3: v = MOST_POS;
                default: v = 64'h1_0000_0000;
            endcase
        end
        if (sel >= 35 && $urandom_range(0, 1))
            v = (~v) + 1'b1;
        return v;
    endfunction

    initial
    begin
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] g;
        logic              k;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero operands, the most negative value, and the saturation boundary.
        send_item(KIND_GCD, 64'd0, 64'd0);
        send_item(KIND_GCD, 64'd25, 64'd0);
        send_item(KIND_GCD, 64'd0, -64'sd40);
        send_item(KIND_GCD, MOST_NEG, 64'd0);
        send_item(KIND_GCD, MOST_NEG, MOST_NEG);
        send_item(KIND_GCD, MOST_POS, MOST_POS);
        send_item(KIND_GCD, MOST_POS, MOST_NEG);
        send_item(KIND_GCD, 64'd12, -64'sd18);
        send_item(KIND_GCD, -64'sd1, -64'sd1);
        send_item(KIND_GCD, 64'd1, MOST_NEG);
        send_item(KIND_LCM, 64'd0, 64'd7);
        send_item(KIND_LCM, -64'sd9, 64'd0);
        send_item(KIND_LCM, 64'd0, 64'd0);
        send_item(KIND_LCM, MOST_NEG, MOST_NEG);
        send_item(KIND_LCM, 64'd4, 64'd6);
        send_item(KIND_LCM, -64'sd3, 64'd5);
        send_item(KIND_LCM, MOST_POS, 64'd1);
        send_item(KIND_LCM, 64'd1, MOST_NEG);
        send_item(KIND_LCM, MOST_NEG, -64'sd1);
        send_item(KIND_LCM, MOST_POS, MOST_POS - 64'd1);
        send_item(KIND_LCM, 64'h1_0000_0000, 64'h8000_0000);
        send_item(KIND_LCM, 64'h4000_0000_0000_0000, 64'd2);
        send_item(KIND_LCM, 64'd3037000499, -64'sd3037000493);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            k = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 25)
            begin
                // Pairs with a shared factor give nontrivial GCDs and unsaturated LCMs.
                g = 64'($urandom_range(1, 1 << 20));
                a = g * 64'($urandom_range(0, 1 << 20));
                b = g * 64'($urandom_range(0, 1 << 20));
                if ($urandom_range(0, 1))
                    a = (~a) + 1'b1;
                if ($urandom_range(0, 1))
                    b = (~b) + 1'b1;
            end
            else
            begin
                a = pick_operand();
                b = pick_operand();
            end
            send_item(k, a, b);
        end
        in_valid <= 1'b0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d GCD items, %0d LCM items, %0d saturated LCMs.",
                 checker_h.checked, checker_h.gcd_items, checker_h.lcm_items,
                 checker_h.saturated);
        $display("Random stalls on both sides plus a %0d-cycle result hold-off with input backed up.",
                 HOLD_CYCLES);
        if (checker_h.failures == 0 && checker_h.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
